// ===== hw/rtl/sqtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtm_pkg
// shared constants for the sample quantile and tail mean block
// ----------------------------------------------------------------------------
package sqtm_pkg;
    localparam int          MAX_SAMPLES = 1024;
    localparam int          DATA_W      = 32;
    localparam int          FRAC_W      = 16;
    localparam logic [15:0] TAIL_RESET  = 16'd3277;
    localparam logic        REG_TAIL    = 1'b0;
endpackage

// ===== hw/rtl/sqtm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sqtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sqtm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqtm_div
// restoring divider, signed dividend by unsigned nonzero divisor, one bit a cycle
// ----------------------------------------------------------------------------
module sqtm_div #(
    parameter int SW = 43,
    parameter int CW = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [SW-1:0]               i_dividend,
    input  logic [CW-1:0]                      i_divisor,
    output logic                               o_done,
    output logic [sqtm_pkg::DATA_W-1:0]        o_quot
);
    localparam int NW = $clog2(SW + 1);

    logic [SW-1:0] r_q;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_d;
    logic [NW-1:0] r_n;
    logic          r_neg;
    logic          r_busy;
    logic          r_done;
    logic [CW:0]   trial;
    logic          fit;

    assign trial = {r_rem[CW-1:0], r_q[SW-1]};
    assign fit   = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_n == NW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_neg <= i_dividend < 0;
            r_q   <= (i_dividend < 0) ? SW'(-i_dividend) : SW'(i_dividend);
            r_rem <= '0;
            r_d   <= i_divisor;
            r_n   <= NW'(SW);
        end else if (r_busy) begin
            r_rem <= fit ? (trial - {1'b0, r_d}) : trial;
            r_q   <= {r_q[SW-2:0], fit};
            r_n   <= r_n - NW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (-r_q[sqtm_pkg::DATA_W-1:0]) : r_q[sqtm_pkg::DATA_W-1:0];
endmodule

// ===== hw/rtl/sample_quantile_and_tail_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_quantile_and_tail_mean
// value at risk and expected shortfall over a loaded set of Q16.16 samples
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one sample per transaction,
// with i_last marking the end of a set. Samples are taken one per cycle into
// a single ram; samples beyond MAX_SAMPLES are dropped and flagged.
// After the last sample the input stalls while the set is processed:
//   insertion sort in the ram, with a key fetch per element followed by one
//   compare/shift per step, then the quantile index computation, a pass over
//   the samples below the quantile index to sum the tail, and the divider.
// One result transaction per set on the output channel (o_out_valid /
// i_out_stall); it is held in an output register while stalled, and loading
// of the next set proceeds meanwhile. A new result waits for the register.
// Reset clears the sample count, drop flag, state and output valid and sets
// tail_fraction to 3277; ram contents stay undefined, and unwritten entries
// are never used. tail_fraction is written over the apb port at address 0.
// ----------------------------------------------------------------------------
module sample_quantile_and_tail_mean #(
    parameter int MAX_SAMPLES = sqtm_pkg::MAX_SAMPLES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [sqtm_pkg::DATA_W-1:0] i_sample_value,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [sqtm_pkg::DATA_W-1:0] o_var_value,
    output logic signed [sqtm_pkg::DATA_W-1:0] o_es_value,
    output logic                              o_es_valid,
    output logic                              o_overflow,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    localparam int DW = sqtm_pkg::DATA_W;
    localparam int FW = sqtm_pkg::FRAC_W;
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = DW + AW + 1;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_KEY   = 11'b00000000100,
        S_CMP   = 11'b00000001000,
        S_PUT   = 11'b00000010000,
        S_IDX   = 11'b00000100000,
        S_IDX2  = 11'b00001000000,
        S_VAR   = 11'b00010000000,
        S_SUM   = 11'b00100000000,
        S_DIVGO = 11'b01000000000,
        S_DIVW  = 11'b10000000000
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_cnt;
    logic                 r_drop;
    logic [FW-1:0]        r_tf;
    logic [CW-1:0]        r_i;
    logic [AW-1:0]        r_j;
    logic [DW-1:0]        r_key;
    logic [CW+FW-1:0]     r_prod;
    logic [CW-1:0]        r_idx;
    logic [DW-1:0]        r_var;
    logic [CW-1:0]        r_k;
    logic signed [SW-1:0] r_sum;
    logic [CW-1:0]        r_hits;
    logic                 r_res;
    logic [DW-1:0]        r_mean;
    logic                 r_ov;
    logic [DW-1:0]        r_o_var;
    logic [DW-1:0]        r_o_es;
    logic                 r_o_esv;
    logic                 r_o_ovf;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [DW-1:0]        wdata;
    logic [AW-1:0]        raddr;
    logic [DW-1:0]        rdata;
    logic                 in_acc;
    logic                 full;
    logic                 move;
    logic [CW-1:0]        pidx;
    logic [CW-1:0]        cidx;
    logic                 div_start;
    logic                 div_done;
    logic [DW-1:0]        div_q;
    logic                 out_free;

    assign o_in_stall = r_state != S_LOAD;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = r_cnt == CW'(MAX_SAMPLES);
    assign move       = $signed(rdata) > $signed(r_key);
    assign pidx       = r_prod[CW+FW-1:FW];
    assign cidx       = (pidx >= r_cnt) ? (r_cnt - CW'(1)) : pidx;
    assign div_start  = (r_state == S_DIVGO) && (r_hits != '0);
    assign out_free   = !r_ov || !i_out_stall;

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        case (r_state)
            S_LOAD: begin
                we    = in_acc && !full;
                waddr = r_cnt[AW-1:0];
                wdata = i_sample_value;
            end
            S_RD:   raddr = r_i[AW-1:0];
            S_KEY:  raddr = r_i[AW-1:0] - AW'(1);
            S_CMP: begin
                we    = 1'b1;
                waddr = r_j;
                wdata = move ? rdata : r_key;
                raddr = r_j - AW'(2);
            end
            S_PUT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = r_key;
            end
            S_IDX2: raddr = cidx[AW-1:0];
            S_VAR:  raddr = '0;
            S_SUM:  raddr = r_k[AW-1:0] + AW'(1);
            default: raddr = '0;
        endcase
    end

    sqtm_ram #(.WIDTH(DW), .DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    sqtm_div #(.SW(SW), .CW(CW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_sum),
        .i_divisor (r_hits),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_tf    <= sqtm_pkg::TAIL_RESET;
            r_ov    <= 1'b0;
            r_res   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == sqtm_pkg::REG_TAIL) begin
                r_tf <= pwdata[FW-1:0];
            end
            if (r_res && out_free) begin
                r_res   <= 1'b0;
                r_ov    <= 1'b1;
                r_o_var <= r_var;
                r_o_es  <= r_mean;
                r_o_esv <= r_hits != '0;
                r_o_ovf <= r_drop;
                r_cnt   <= '0;
                r_drop  <= 1'b0;
                r_state <= S_LOAD;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (i_last) begin
                            r_i     <= CW'(1);
                            r_state <= ((full ? r_cnt : r_cnt + CW'(1)) > CW'(1)) ? S_RD : S_IDX;
                        end
                    end
                end
                S_RD:  r_state <= S_KEY;
                S_KEY: begin
                    r_key   <= rdata;
                    r_j     <= r_i[AW-1:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (move) begin
                        r_j <= r_j - AW'(1);
                        if (r_j == AW'(1)) begin
                            r_state <= S_PUT;
                        end
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= (r_i + CW'(1) < r_cnt) ? S_RD : S_IDX;
                    end
                end
                S_PUT: begin
                    r_i     <= r_i + CW'(1);
                    r_state <= (r_i + CW'(1) < r_cnt) ? S_RD : S_IDX;
                end
                S_IDX: begin
                    r_prod  <= r_cnt * r_tf;
                    r_state <= S_IDX2;
                end
                S_IDX2: begin
                    r_idx   <= cidx;
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    r_var   <= rdata;
                    r_k     <= '0;
                    r_sum   <= '0;
                    r_hits  <= '0;
                    r_state <= (r_idx == '0) ? S_DIVGO : S_SUM;
                end
                S_SUM: begin
                    if ($signed(rdata) < $signed(r_var)) begin
                        r_sum  <= r_sum + SW'($signed(rdata));
                        r_hits <= r_hits + CW'(1);
                    end
                    r_k <= r_k + CW'(1);
                    if (r_k + CW'(1) == r_idx) begin
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    if (r_hits == '0) begin
                        r_mean  <= '0;
                        r_res   <= 1'b1;
                        r_state <= S_DIVW;
                    end else begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_mean <= div_q;
                        r_res  <= 1'b1;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_var_value = r_o_var;
    assign o_es_value  = r_o_es;
    assign o_es_valid  = r_o_esv;
    assign o_overflow  = r_o_ovf;
    assign prdata      = (paddr[2] == sqtm_pkg::REG_TAIL) ? {16'd0, r_tf} : 32'd0;
    assign pready      = 1'b1;
endmodule
